### rtl/gap_buffer_text_engine_top_assert.svh
// Assertion macros for the gap buffer text engine
`ifndef GAP_BUFFER_TEXT_ENGINE_TOP_ASSERT_SVH
`define GAP_BUFFER_TEXT_ENGINE_TOP_ASSERT_SVH

// Implication checked every clock outside reset
`define GB_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("gap buffer check failed");

// Next-cycle implication checked outside reset
`define GB_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("gap buffer check failed");

`endif

### rtl/gbte_pkg.sv
`default_nettype none
package gbte_pkg;
   localparam int CAPACITY = 1024;
   localparam int AW = $clog2(CAPACITY);
   localparam int PW = 11;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_DELETE = 2'd1;
   localparam logic [1:0] OP_MOVE   = 2'd2;
   localparam logic [1:0] OP_READ   = 2'd3;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;

   localparam logic [6:0] GROW_STEP_RESET = 7'd10;

   typedef struct packed {
      logic [1:0]    func;
      logic [PW-1:0] position;
      logic [7:0]    char_in;
   } req_type;

   typedef struct packed {
      logic [7:0]    char_out;
      logic [1:0]    status;
      logic [PW-1:0] cursor_out;
      logic [PW-1:0] text_length;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE, S_DECIDE, S_MVL_RD, S_MVL_WR, S_MVR_RD, S_MVR_WR,
      S_GROW_RD, S_GROW_WR, S_PUT, S_RD_WAIT, S_RD_DONE, S_OUT
   } state_type;
endpackage
`default_nettype wire

### rtl/gbte_ram.sv
`default_nettype none
module gbte_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

### rtl/gbte_front.sv
`default_nettype none
// Two-entry request queue between the port and the engine
module gbte_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire gbte_pkg::req_type req_data,
   output logic                   q_valid,
   input  wire logic              q_take,
   output gbte_pkg::req_type      q_data
);
   gbte_pkg::req_type ent_ff [2];
   gbte_pkg::req_type ent_in [2];
   logic       rp_ff, rp_in, wp_ff, wp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;

   assign req_stall = (cnt_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_data    = ent_ff[rp_ff];

   always_comb begin
      ent_in = ent_ff;
      if (push) begin
         ent_in[wp_ff] = req_data;
      end
      wp_in  = push ? !wp_ff : wp_ff;
      rp_in  = q_take ? !rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, q_take};
   end

   always_ff @(posedge clock) begin
      ent_ff <= ent_in;
      if (reset) begin
         rp_ff  <= 1'b0;
         wp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         rp_ff  <= rp_in;
         wp_ff  <= wp_in;
         cnt_ff <= cnt_in;
      end
   end
endmodule
`default_nettype wire

### rtl/gbte_back.sv
`default_nettype none
// Carries out one request at a time, walking the store one slot per step
module gbte_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [6:0]        grow_step,
   input  wire logic              q_valid,
   output logic                   q_take,
   input  wire gbte_pkg::req_type q_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output gbte_pkg::rsp_type      rsp_data,
   output logic                   busy
);
   localparam int AW = gbte_pkg::AW;
   localparam int PW = gbte_pkg::PW;
   localparam int CW = AW + 2;

   gbte_pkg::state_type st_ff, st_in;
   gbte_pkg::req_type   op_ff, op_in;
   logic [CW-1:0] gs_ff, gs_in, ge_ff, ge_in, ul_ff, ul_in, idx_ff, idx_in;
   logic [CW-1:0] tgt_ff, tgt_in;
   logic [6:0]    k_ff, k_in;
   logic          grow_ff, grow_in;
   logic [1:0]    stat_ff, stat_in;
   logic [7:0]    cout_ff, cout_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [7:0]    wr_data, rd_data;
   logic [CW-1:0] len, gsize, pos, kx;
   logic          rng_gt, rng_ge;

   gbte_ram #(.WIDTH(8), .DEPTH(gbte_pkg::CAPACITY)) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign gsize  = ge_ff - gs_ff + CW'(1);
   assign len    = ul_ff - gsize;
   assign pos    = CW'(op_ff.position);
   assign kx     = CW'(k_ff);
   assign rng_gt = pos > len;
   assign rng_ge = pos >= len;

   always_comb begin
      st_in = st_ff;
      case (st_ff)
         gbte_pkg::S_IDLE:    if (q_valid) st_in = gbte_pkg::S_DECIDE;
         gbte_pkg::S_DECIDE: begin
            st_in = gbte_pkg::S_OUT;
            case (op_ff.func)
               gbte_pkg::OP_READ: if (!rng_ge) st_in = gbte_pkg::S_RD_WAIT;
               gbte_pkg::OP_INSERT:
                  if (!rng_gt && !(ge_ff == gs_ff && ul_ff + kx > CW'(gbte_pkg::CAPACITY)))
                     st_in = gbte_pkg::S_MVL_RD;
               gbte_pkg::OP_DELETE: if (!rng_ge) st_in = gbte_pkg::S_MVL_RD;
               gbte_pkg::OP_MOVE:   if (!rng_gt) st_in = gbte_pkg::S_MVL_RD;
               default: st_in = gbte_pkg::S_OUT;
            endcase
         end
         gbte_pkg::S_MVL_RD: begin
            if (tgt_ff < gs_ff)      st_in = gbte_pkg::S_MVL_WR;
            else if (tgt_ff > gs_ff) st_in = gbte_pkg::S_MVR_RD;
            else if (grow_ff)        st_in = gbte_pkg::S_GROW_RD;
            else if (op_ff.func == gbte_pkg::OP_INSERT) st_in = gbte_pkg::S_PUT;
            else                     st_in = gbte_pkg::S_OUT;
         end
         gbte_pkg::S_MVL_WR:  st_in = gbte_pkg::S_MVL_RD;
         gbte_pkg::S_MVR_RD:  st_in = gbte_pkg::S_MVR_WR;
         gbte_pkg::S_MVR_WR:  st_in = gbte_pkg::S_MVL_RD;
         gbte_pkg::S_GROW_RD:
            st_in = (idx_ff > ge_ff + CW'(1)) ? gbte_pkg::S_GROW_WR : gbte_pkg::S_PUT;
         gbte_pkg::S_GROW_WR: st_in = gbte_pkg::S_GROW_RD;
         gbte_pkg::S_PUT:     st_in = gbte_pkg::S_OUT;
         gbte_pkg::S_RD_WAIT: st_in = gbte_pkg::S_RD_DONE;
         gbte_pkg::S_RD_DONE: st_in = gbte_pkg::S_OUT;
         gbte_pkg::S_OUT:     if (!rsp_stall) st_in = gbte_pkg::S_IDLE;
         default:             st_in = gbte_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      op_in = op_ff; gs_in = gs_ff; ge_in = ge_ff; ul_in = ul_ff; idx_in = idx_ff;
      tgt_in = tgt_ff; k_in = k_ff; grow_in = grow_ff; stat_in = stat_ff;
      cout_in = cout_ff;
      q_take = 1'b0; wr_en = 1'b0; wr_addr = '0; wr_data = rd_data; rd_addr = '0;
      case (st_ff)
         gbte_pkg::S_IDLE: begin
            q_take = q_valid;
            if (q_valid) op_in = q_data;
            k_in    = (grow_step == 7'd0) ? 7'd1 : grow_step;
            stat_in = gbte_pkg::ST_OK;
            cout_in = 8'd0;
         end
         gbte_pkg::S_DECIDE: begin
            grow_in = (op_ff.func == gbte_pkg::OP_INSERT) && (ge_ff == gs_ff);
            tgt_in  = (op_ff.func == gbte_pkg::OP_DELETE) ? pos + CW'(1) : pos;
            idx_in  = ul_ff;
            case (op_ff.func)
               gbte_pkg::OP_READ: begin
                  if (rng_ge) stat_in = gbte_pkg::ST_RANGE;
               end
               gbte_pkg::OP_INSERT: begin
                  if (rng_gt) stat_in = gbte_pkg::ST_RANGE;
                  else if (ge_ff == gs_ff && ul_ff + kx > CW'(gbte_pkg::CAPACITY))
                     stat_in = gbte_pkg::ST_FULL;
               end
               gbte_pkg::OP_DELETE: if (rng_ge) stat_in = gbte_pkg::ST_RANGE;
               default:             if (rng_gt) stat_in = gbte_pkg::ST_RANGE;
            endcase
            rd_addr = (pos < gs_ff) ? AW'(pos) : AW'(pos + gsize);
         end
         gbte_pkg::S_MVL_RD: begin
            // Read the character left of the gap
            rd_addr = AW'(gs_ff - CW'(1));
            if (tgt_ff == gs_ff && !grow_ff && op_ff.func == gbte_pkg::OP_DELETE)
               gs_in = gs_ff - CW'(1);
         end
         gbte_pkg::S_MVL_WR: begin
            wr_en   = 1'b1;
            wr_addr = AW'(ge_ff);
            gs_in   = gs_ff - CW'(1);
            ge_in   = ge_ff - CW'(1);
         end
         gbte_pkg::S_MVR_RD: rd_addr = AW'(ge_ff + CW'(1));
         gbte_pkg::S_MVR_WR: begin
            wr_en   = 1'b1;
            wr_addr = AW'(gs_ff);
            gs_in   = gs_ff + CW'(1);
            ge_in   = ge_ff + CW'(1);
         end
         gbte_pkg::S_GROW_RD: begin
            // Shift the tail right by the step, last slot first
            rd_addr = AW'(idx_ff - CW'(1));
            if (!(idx_ff > ge_ff + CW'(1))) begin
               ge_in = ge_ff + kx;
               ul_in = ul_ff + kx;
            end
         end
         gbte_pkg::S_GROW_WR: begin
            wr_en   = 1'b1;
            wr_addr = AW'(idx_ff - CW'(1) + kx);
            idx_in  = idx_ff - CW'(1);
         end
         gbte_pkg::S_PUT: begin
            wr_en   = 1'b1;
            wr_addr = AW'(gs_ff);
            wr_data = op_ff.char_in;
            gs_in   = gs_ff + CW'(1);
         end
         // Hold the read address so the data still holds in S_RD_DONE
         gbte_pkg::S_RD_WAIT: rd_addr = (pos < gs_ff) ? AW'(pos) : AW'(pos + gsize);
         gbte_pkg::S_RD_DONE: cout_in = rd_data;
         default: ;
      endcase
   end

   assign rsp_valid            = (st_ff == gbte_pkg::S_OUT);
   assign rsp_data.char_out    = cout_ff;
   assign rsp_data.status      = stat_ff;
   assign rsp_data.cursor_out  = PW'(gs_ff);
   assign rsp_data.text_length = PW'(len);
   assign busy                 = (st_ff != gbte_pkg::S_IDLE);

   always_ff @(posedge clock) begin
      op_ff <= op_in; idx_ff <= idx_in; tgt_ff <= tgt_in; k_ff <= k_in;
      grow_ff <= grow_in; stat_ff <= stat_in; cout_ff <= cout_in;
      if (reset) begin
         st_ff <= gbte_pkg::S_IDLE;
         gs_ff <= '0;
         ge_ff <= '0;
         ul_ff <= CW'(1);
      end else begin
         st_ff <= st_in;
         gs_ff <= gs_in;
         ge_ff <= ge_in;
         ul_ff <= ul_in;
      end
   end
endmodule
`default_nettype wire

### rtl/gap_buffer_text_engine_top.sv
// channel | direction | handshake         | payload
// req     | in        | req_valid/stall   | gbte_pkg::req_type
// rsp     | out       | rsp_valid/stall   | gbte_pkg::rsp_type
// csr     | in        | csr_valid/ready   | grow_step, 7 bits
// A request that is out of range or full goes straight to its response. A move or
// delete first walks the gap to the position, a read fetches the character, and an
// insert walks the gap, shifts the tail right by the step when the gap is down to one
// slot, and writes the character. One request at a time walks the store.
// Synchronous reset empties the text and sets the step to 10.
// A stalled response holds the engine; the two-entry queue accepts until it fills.
`default_nettype none
module gap_buffer_text_engine_top (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire gbte_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output gbte_pkg::rsp_type      rsp_data,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [6:0]        csr_data
);
   `include "gap_buffer_text_engine_top_assert.svh"

   logic [6:0]        step_ff, step_in;
   logic              q_valid, q_take, busy;
   gbte_pkg::req_type q_data;

   assign csr_ready = 1'b1;
   assign step_in   = (csr_valid && csr_ready) ? csr_data : step_ff;

   always_ff @(posedge clock) begin
      if (reset) step_ff <= gbte_pkg::GROW_STEP_RESET;
      else       step_ff <= step_in;
   end

   gbte_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .q_valid, .q_take, .q_data
   );

   gbte_back u_back (
      .clock, .reset, .grow_step(step_ff), .q_valid, .q_take, .q_data,
      .rsp_valid, .rsp_stall, .rsp_data, .busy
   );

   `GB_ASSERT_IMP(a_take_idle, q_take, q_valid && !busy)
   `GB_ASSERT_NXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))
   `GB_ASSERT_IMP(a_status_code, rsp_valid, rsp_data.status <= gbte_pkg::ST_RANGE)
endmodule
`default_nettype wire

### test/tb_gap_buffer_text_engine_top.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_gap_buffer_text_engine_top;
   localparam longint CYCLE_LIMIT = 64'd40000000;
   localparam int PW = gbte_pkg::PW;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   gbte_pkg::req_type req_data;
   logic rsp_valid;
   logic rsp_stall;
   gbte_pkg::rsp_type rsp_data;
   logic csr_valid;
   logic csr_ready;
   logic [6:0] csr_data;

   gap_buffer_text_engine_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   // predicted engine state
   logic [7:0] text_mem [gbte_pkg::CAPACITY];
   int unsigned gap_lo, gap_hi, slots_used, step_cfg;

   gbte_pkg::rsp_type pending_rsp[$];
   int unsigned mismatches;
   longint cycles = 0;
   int stall_mode = 0;

   typedef struct {
      gbte_pkg::req_type req;
      logic              typed;
      gbte_pkg::rsp_type rsp;
   } directed_row_type;

   function automatic int unsigned text_count();
      return slots_used - (gap_hi - gap_lo + 1);
   endfunction

   function automatic void shift_gap(int unsigned p);
      while (p < gap_lo) begin
         gap_lo--;
         gap_hi--;
         text_mem[gap_hi + 1] = text_mem[gap_lo];
      end
      while (p > gap_lo) begin
         gap_lo++;
         gap_hi++;
         text_mem[gap_lo - 1] = text_mem[gap_hi];
      end
   endfunction

   function automatic gbte_pkg::rsp_type edit_text(gbte_pkg::req_type r);
      gbte_pkg::rsp_type o;
      int unsigned len, k, i;
      logic grow;
      len = text_count();
      o = '0;
      o.status = gbte_pkg::ST_OK;
      case (r.func)
         gbte_pkg::OP_INSERT: begin
            k = (step_cfg == 0) ? 1 : step_cfg;
            grow = (gap_hi == gap_lo);
            if (r.position > len) o.status = gbte_pkg::ST_RANGE;
            else if (grow && slots_used + k > gbte_pkg::CAPACITY) o.status = gbte_pkg::ST_FULL;
            else begin
               shift_gap(r.position);
               if (grow) begin
                  i = slots_used;
                  while (i > gap_hi + 1) begin
                     i--;
                     text_mem[i + k] = text_mem[i];
                  end
                  gap_hi += k;
                  slots_used += k;
               end
               text_mem[gap_lo] = r.char_in;
               gap_lo++;
            end
         end
         gbte_pkg::OP_DELETE: begin
            if (r.position >= len) o.status = gbte_pkg::ST_RANGE;
            else begin
               shift_gap(r.position + 1);
               gap_lo--;
            end
         end
         gbte_pkg::OP_MOVE: begin
            if (r.position > len) o.status = gbte_pkg::ST_RANGE;
            else shift_gap(r.position);
         end
         default: begin
            if (r.position >= len) o.status = gbte_pkg::ST_RANGE;
            else if (r.position < gap_lo) o.char_out = text_mem[r.position];
            else o.char_out = text_mem[r.position + gap_hi - gap_lo + 1];
         end
      endcase
      o.cursor_out = PW'(gap_lo);
      o.text_length = PW'(text_count());
      return o;
   endfunction

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // receiver stall pattern: modes of none, light, heavy, periodic
   always @(posedge clock) begin
      if (!reset && (cycles % 500) == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 7) == 0);
         2: rsp_stall <= ($urandom_range(0, 1) == 0);
         default: rsp_stall <= (cycles % 7) < 3;
      endcase
   end

   always @(posedge clock) begin
      gbte_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %p", rsp_data);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %p, got %p", want, rsp_data);
            end
         end
      end
   end

   // present one request, hold until accepted, then predict
   task automatic send_request(gbte_pkg::req_type r, logic typed,
                               gbte_pkg::rsp_type typed_rsp);
      gbte_pkg::rsp_type got;
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      got = edit_text(r);
      if (typed && got !== typed_rsp) begin
         mismatches++;
         if (mismatches <= 10)
            $display("table row: expected %p, predicted %p", typed_rsp, got);
      end
      pending_rsp.push_back(got);
   endtask

   task automatic send_burst_gap();
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic write_step(logic [6:0] v);
      while (pending_rsp.size() != 0) @(posedge clock);
      req_valid <= 1'b0;
      repeat (20) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      step_cfg = v;
   endtask

   function automatic gbte_pkg::req_type make_req(logic [1:0] f, int unsigned p,
                                                  logic [7:0] c);
      gbte_pkg::req_type r;
      r.func = f;
      r.position = p[PW-1:0];
      r.char_in = c;
      return r;
   endfunction

   function automatic gbte_pkg::rsp_type make_rsp(logic [7:0] c, logic [1:0] s,
                                                  int unsigned cur, int unsigned len);
      gbte_pkg::rsp_type o;
      o.char_out = c;
      o.status = s;
      o.cursor_out = cur[PW-1:0];
      o.text_length = len[PW-1:0];
      return o;
   endfunction

   // random mix biased to in-range positions; a fill phase drives the store to full
   task automatic random_phase(int n, int insert_weight);
      gbte_pkg::req_type r;
      int unsigned len, sel;
      for (int i = 0; i < n; i++) begin
         len = text_count();
         sel = $urandom_range(0, 99);
         if (sel < insert_weight) r.func = gbte_pkg::OP_INSERT;
         else r.func = 2'($urandom_range(1, 3));
         case ($urandom_range(0, 9))
            0: r.position = PW'($urandom_range(0, 2047));
            1: r.position = PW'(len);
            2: r.position = '0;
            default: r.position = PW'($urandom_range(0, len));
         endcase
         r.char_in = 8'($urandom);
         send_request(r, 1'b0, '0);
         send_burst_gap();
      end
      req_valid <= 1'b0;
   endtask

   initial begin
      directed_row_type rows[$];
      directed_row_type row;
      mismatches = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      gap_lo = 0;
      gap_hi = 0;
      slots_used = 1;
      step_cfg = gbte_pkg::GROW_STEP_RESET;
      foreach (text_mem[i]) text_mem[i] = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty text: accesses past the end are out of range, a move or insert at 0 is accepted
      rows.push_back('{make_req(gbte_pkg::OP_READ, 0, 8'h00), 1'b1,
                       make_rsp(8'h00, gbte_pkg::ST_RANGE, 0, 0)});
      rows.push_back('{make_req(gbte_pkg::OP_DELETE, 0, 8'h00), 1'b1,
                       make_rsp(8'h00, gbte_pkg::ST_RANGE, 0, 0)});
      rows.push_back('{make_req(gbte_pkg::OP_MOVE, 1, 8'h00), 1'b1,
                       make_rsp(8'h00, gbte_pkg::ST_RANGE, 0, 0)});
      rows.push_back('{make_req(gbte_pkg::OP_INSERT, 2047, 8'hFF), 1'b1,
                       make_rsp(8'h00, gbte_pkg::ST_RANGE, 0, 0)});
      rows.push_back('{make_req(gbte_pkg::OP_MOVE, 0, 8'h00), 1'b1,
                       make_rsp(8'h00, gbte_pkg::ST_OK, 0, 0)});
      rows.push_back('{make_req(gbte_pkg::OP_INSERT, 0, 8'hFF), 1'b1,
                       make_rsp(8'h00, gbte_pkg::ST_OK, 1, 1)});
      rows.push_back('{make_req(gbte_pkg::OP_READ, 0, 8'h00), 1'b1,
                       make_rsp(8'hFF, gbte_pkg::ST_OK, 1, 1)});
      rows.push_back('{make_req(gbte_pkg::OP_INSERT, 0, 8'h00), 1'b0, '0});
      rows.push_back('{make_req(gbte_pkg::OP_INSERT, 2, 8'hA5), 1'b0, '0});
      rows.push_back('{make_req(gbte_pkg::OP_INSERT, 1, 8'h5A), 1'b0, '0});
      rows.push_back('{make_req(gbte_pkg::OP_READ, 3, 8'h00), 1'b0, '0});
      rows.push_back('{make_req(gbte_pkg::OP_MOVE, 0, 8'h00), 1'b0, '0});
      rows.push_back('{make_req(gbte_pkg::OP_READ, 3, 8'h00), 1'b0, '0});
      rows.push_back('{make_req(gbte_pkg::OP_MOVE, 4, 8'h00), 1'b0, '0});
      rows.push_back('{make_req(gbte_pkg::OP_READ, 4, 8'h00), 1'b1,
                       make_rsp(8'h00, gbte_pkg::ST_RANGE, 4, 4)});
      rows.push_back('{make_req(gbte_pkg::OP_DELETE, 4, 8'h00), 1'b1,
                       make_rsp(8'h00, gbte_pkg::ST_RANGE, 4, 4)});
      rows.push_back('{make_req(gbte_pkg::OP_DELETE, 0, 8'h00), 1'b0, '0});
      rows.push_back('{make_req(gbte_pkg::OP_DELETE, 2, 8'h00), 1'b0, '0});
      rows.push_back('{make_req(gbte_pkg::OP_READ, 1, 8'h00), 1'b0, '0});
      rows.push_back('{make_req(gbte_pkg::OP_MOVE, 2047, 8'h00), 1'b0, '0});
      foreach (rows[i]) begin
         row = rows[i];
         send_request(row.req, row.typed, row.rsp);
         send_burst_gap();
      end
      req_valid <= 1'b0;

      // extremes of the register and a mid step; the long insert-heavy run fills the store
      write_step(7'd1);
      random_phase(120, 55);
      write_step(7'd64);
      random_phase(100, 45);
      write_step(7'd0);
      random_phase(60, 40);
      write_step(7'd127);
      random_phase(60, 50);
      write_step(7'd33);
      random_phase(1150, 98);
      random_phase(90, 20);

      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (mismatches == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end
endmodule
`default_nettype wire

### sim.f
+incdir+rtl
rtl/gbte_pkg.sv
rtl/gbte_ram.sv
rtl/gbte_front.sv
rtl/gbte_back.sv
rtl/gap_buffer_text_engine_top.sv
test/tb_gap_buffer_text_engine_top.sv
